### sv/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types and constants of the symbol intern table.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int POOL_BYTES_DEF  = 4096;
  localparam int MAX_NAME_DEF    = 64;

  localparam int LEN_W   = 7;
  localparam int HASH_W  = 64;
  localparam int PRIME_SHIFT = 40;

  localparam logic [HASH_W-1:0] FNV_BASIS    = 64'hcbf29ce484222325;
  localparam logic [HASH_W-1:0] FNV_PRIME_LO = 64'd435;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CASE_BIT     = 8'h20;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_TOO_LONG   = 2'd1,
    STAT_TABLE_FULL = 2'd2,
    STAT_POOL_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_DECIDE,
    S_READ,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        name_byte;
    logic              last;
    logic [HASH_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic              is_new;
    logic              found;
    logic [7:0]        text_byte;
    logic              end_of_run;
    status_t           status;
  } out_t;

  typedef struct packed {
    logic cmp;
    logic ins;
  } cell_ctl_t;

endpackage

### sv/symbol_intern_table_unit.sv
// ----------------------------------------------------------------------------
// symbol_intern_table_unit
// Interns lower-cased names under a 64-bit FNV-1 hash in a sorted cell row
// and streams stored names back on lookup by hash.
//
//   channel | dir | ports                      | request
//   in      | in  | in_valid in_ready in_data  | name byte or lookup key
//   out     | out | out_valid out_ready out_data | one result (0..64 per request)
//
// A name byte that is not last stays in the idle state. A last byte
// or a lookup passes through compare in every cell, then decide and insert;
// a lookup hit then streams each byte through a pool read and an emit state.
// The output register waits for out_ready; a stall holds the sequencer.
// Reset is synchronous; the table and pool contents need no clearing.
// ----------------------------------------------------------------------------
module symbol_intern_table_unit #(
  parameter int TABLE_DEPTH = sit_pkg::TABLE_DEPTH_DEF,
  parameter int POOL_BYTES  = sit_pkg::POOL_BYTES_DEF,
  parameter int MAX_NAME    = sit_pkg::MAX_NAME_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sit_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sit_pkg::out_t out_data
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int OFF_W = $clog2(POOL_BYTES + 1);
  localparam int AW    = $clog2(POOL_BYTES);
  localparam int LW    = sit_pkg::LEN_W;

  sit_pkg::state_t            st_r, st_nxt;
  logic [sit_pkg::HASH_W-1:0] hash_r, key_r;
  logic [LW-1:0]              name_len_r, fin_len_r, idx_r, rd_len_r;
  logic                       ovf_r, fin_ovf_r, lookup_r;
  logic [CNT_W-1:0]           count_r;
  logic [OFF_W-1:0]           top_r, rd_off_r;
  logic                       out_valid_r;
  sit_pkg::out_t              out_data_r;

  logic                       accept, out_free, load_out;
  logic [7:0]                 low_byte;
  logic [sit_pkg::HASH_W-1:0] hash_step;
  logic [OFF_W:0]             wsum;
  logic                       pool_we, pool_re;
  logic [7:0]                 pool_rdata;
  sit_pkg::cell_ctl_t         ctl;
  logic                       found;
  logic [OFF_W-1:0]           hit_off;
  logic [LW-1:0]              hit_len;
  logic                       do_ins, stream_end;
  sit_pkg::status_t           reg_status;
  sit_pkg::out_t              out_load;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // lower-case and hash step
  always_comb begin
    low_byte = in_data.name_byte;
    if (low_byte >= sit_pkg::CHAR_UPPER_A && low_byte <= sit_pkg::CHAR_UPPER_Z) begin
      low_byte = low_byte | sit_pkg::CASE_BIT;
    end
    hash_step = ((hash_r << sit_pkg::PRIME_SHIFT) + hash_r * sit_pkg::FNV_PRIME_LO)
                ^ {56'd0, low_byte};
  end

  assign wsum    = {1'b0, top_r} + (OFF_W+1)'(name_len_r);
  assign pool_we = accept && !in_data.kind && !ovf_r && (name_len_r < LW'(MAX_NAME))
                   && (wsum < (OFF_W+1)'(POOL_BYTES));

  always_comb begin
    priority if (fin_ovf_r) begin
      reg_status = sit_pkg::STAT_TOO_LONG;
    end else if (found) begin
      reg_status = sit_pkg::STAT_OK;
    end else if (count_r == CNT_W'(TABLE_DEPTH)) begin
      reg_status = sit_pkg::STAT_TABLE_FULL;
    end else if (OFF_W'(fin_len_r) > (OFF_W'(POOL_BYTES) - top_r)) begin
      reg_status = sit_pkg::STAT_POOL_FULL;
    end else begin
      reg_status = sit_pkg::STAT_OK;
    end
  end

  assign stream_end = (LW'(idx_r + LW'(1)) == rd_len_r);

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      sit_pkg::S_IDLE: begin
        if (accept && (in_data.kind || in_data.last)) begin
          st_nxt = sit_pkg::S_CMP;
        end
      end
      sit_pkg::S_CMP: st_nxt = sit_pkg::S_DECIDE;
      sit_pkg::S_DECIDE: begin
        if (out_free) begin
          st_nxt = (lookup_r && found) ? sit_pkg::S_READ : sit_pkg::S_IDLE;
        end
      end
      sit_pkg::S_READ: st_nxt = sit_pkg::S_EMIT;
      sit_pkg::S_EMIT: begin
        if (out_free) begin
          st_nxt = stream_end ? sit_pkg::S_IDLE : sit_pkg::S_READ;
        end
      end
      default: st_nxt = sit_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    ctl      = '0;
    do_ins   = 1'b0;
    pool_re  = 1'b0;
    load_out = 1'b0;
    out_load = '0;
    unique case (st_r)
      sit_pkg::S_IDLE: in_ready = 1'b1;
      sit_pkg::S_CMP:  ctl.cmp = 1'b1;
      sit_pkg::S_DECIDE: begin
        if (out_free) begin
          out_load.hash       = key_r;
          out_load.end_of_run = 1'b1;
          if (lookup_r) begin
            load_out        = !found;
            out_load.status = sit_pkg::STAT_OK;
          end else begin
            do_ins          = !fin_ovf_r && !found && (reg_status == sit_pkg::STAT_OK);
            load_out        = 1'b1;
            out_load.is_new = do_ins;
            out_load.status = reg_status;
          end
          ctl.ins = do_ins;
        end
      end
      sit_pkg::S_READ: pool_re = 1'b1;
      sit_pkg::S_EMIT: begin
        if (out_free) begin
          load_out            = 1'b1;
          out_load.hash       = key_r;
          out_load.found      = 1'b1;
          out_load.text_byte  = pool_rdata;
          out_load.end_of_run = stream_end;
          out_load.status     = sit_pkg::STAT_OK;
        end
      end
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= sit_pkg::S_IDLE;
      hash_r      <= sit_pkg::FNV_BASIS;
      name_len_r  <= '0;
      ovf_r       <= 1'b0;
      count_r     <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (accept && !in_data.kind) begin
        if (in_data.last) begin
          hash_r     <= sit_pkg::FNV_BASIS;
          name_len_r <= '0;
          ovf_r      <= 1'b0;
        end else begin
          hash_r <= hash_step;
          if (!ovf_r && name_len_r < LW'(MAX_NAME)) begin
            name_len_r <= LW'(name_len_r + LW'(1));
          end else begin
            ovf_r <= 1'b1;
          end
        end
      end
      if (do_ins) begin
        count_r <= CNT_W'(count_r + CNT_W'(1));
        top_r   <= OFF_W'(top_r + OFF_W'(fin_len_r));
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lookup_r <= in_data.kind;
      if (in_data.kind) begin
        key_r <= in_data.key;
      end else if (in_data.last) begin
        key_r <= hash_step;
        if (!ovf_r && name_len_r < LW'(MAX_NAME)) begin
          fin_len_r <= LW'(name_len_r + LW'(1));
          fin_ovf_r <= 1'b0;
        end else begin
          fin_len_r <= name_len_r;
          fin_ovf_r <= 1'b1;
        end
      end
    end
    if (st_r == sit_pkg::S_DECIDE) begin
      rd_off_r <= hit_off;
      rd_len_r <= hit_len;
      idx_r    <= '0;
    end else if (st_r == sit_pkg::S_EMIT && out_free) begin
      idx_r <= LW'(idx_r + LW'(1));
    end
    if (load_out) begin
      out_data_r <= out_load;
    end
  end

  sit_cell_row #(.TABLE_DEPTH(TABLE_DEPTH), .CNT_W(CNT_W), .OFF_W(OFF_W)) u_row (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .key(key_r),
    .new_off(top_r), .new_len(fin_len_r), .count(count_r),
    .found(found), .hit_off(hit_off), .hit_len(hit_len)
  );

  sit_pool #(.POOL_BYTES(POOL_BYTES), .AW(AW)) u_pool (
    .clk(clk),
    .we(pool_we),
    .waddr(wsum[AW-1:0]),
    .wdata(low_byte),
    .re(pool_re),
    .raddr(AW'(rd_off_r + OFF_W'(idx_r))),
    .rdata(pool_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/sit_cell.sv
// ----------------------------------------------------------------------------
// sit_cell
// One table slot: holds a hash with its pool place, compares against the
// broadcast key and shifts right from its neighbour on a sorted insert.
// ----------------------------------------------------------------------------
module sit_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 9,
  parameter int OFF_W = 13
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sit_pkg::cell_ctl_t          ctl,
  input  logic [sit_pkg::HASH_W-1:0]  key,
  input  logic [OFF_W-1:0]            new_off,
  input  logic [sit_pkg::LEN_W-1:0]   new_len,
  input  logic [CNT_W-1:0]            count,
  input  logic [sit_pkg::HASH_W-1:0]  prev_hash,
  input  logic [OFF_W-1:0]            prev_off,
  input  logic [sit_pkg::LEN_W-1:0]   prev_len,
  input  logic                        prev_lt,
  output logic [sit_pkg::HASH_W-1:0]  hash_o,
  output logic [OFF_W-1:0]            off_o,
  output logic [sit_pkg::LEN_W-1:0]   len_o,
  output logic                        lt_o,
  output logic                        eq_o
);

  logic [sit_pkg::HASH_W-1:0] hash_r;
  logic [OFF_W-1:0]           off_r;
  logic [sit_pkg::LEN_W-1:0]  len_r;
  logic                       lt_r;
  logic                       eq_r;
  logic                       live;

  assign live = CNT_W'(IDX) < count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else if (ctl.cmp) begin
      lt_r <= live && (hash_r < key);
      eq_r <= live && (hash_r == key);
    end
  end

  // cells below the insert point keep their contents
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (!prev_lt) begin
        hash_r <= prev_hash;
        off_r  <= prev_off;
        len_r  <= prev_len;
      end else if (!lt_r) begin
        hash_r <= key;
        off_r  <= new_off;
        len_r  <= new_len;
      end
    end
  end

  assign hash_o = hash_r;
  assign off_o  = off_r;
  assign len_o  = len_r;
  assign lt_o   = lt_r;
  assign eq_o   = eq_r;

endmodule

### sv/sit_cell_row.sv
// ----------------------------------------------------------------------------
// sit_cell_row
// Row of table cells kept in ascending hash order, with hit detection and
// selection of the matching pool place.
// ----------------------------------------------------------------------------
module sit_cell_row #(
  parameter int TABLE_DEPTH = sit_pkg::TABLE_DEPTH_DEF,
  parameter int CNT_W       = 9,
  parameter int OFF_W       = 13
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sit_pkg::cell_ctl_t          ctl,
  input  logic [sit_pkg::HASH_W-1:0]  key,
  input  logic [OFF_W-1:0]            new_off,
  input  logic [sit_pkg::LEN_W-1:0]   new_len,
  input  logic [CNT_W-1:0]            count,
  output logic                        found,
  output logic [OFF_W-1:0]            hit_off,
  output logic [sit_pkg::LEN_W-1:0]   hit_len
);

  logic [sit_pkg::HASH_W-1:0] c_hash [TABLE_DEPTH];
  logic [OFF_W-1:0]           c_off  [TABLE_DEPTH];
  logic [sit_pkg::LEN_W-1:0]  c_len  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]     c_lt;
  logic [TABLE_DEPTH-1:0]     c_eq;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      sit_cell #(.IDX(g), .CNT_W(CNT_W), .OFF_W(OFF_W)) u_cell (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .key(key),
        .new_off(new_off), .new_len(new_len), .count(count),
        .prev_hash(key), .prev_off(new_off), .prev_len(new_len),
        .prev_lt(1'b1),
        .hash_o(c_hash[g]), .off_o(c_off[g]), .len_o(c_len[g]),
        .lt_o(c_lt[g]), .eq_o(c_eq[g])
      );
    end else begin : g_body
      sit_cell #(.IDX(g), .CNT_W(CNT_W), .OFF_W(OFF_W)) u_cell (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .key(key),
        .new_off(new_off), .new_len(new_len), .count(count),
        .prev_hash(c_hash[g-1]), .prev_off(c_off[g-1]), .prev_len(c_len[g-1]),
        .prev_lt(c_lt[g-1]),
        .hash_o(c_hash[g]), .off_o(c_off[g]), .len_o(c_len[g]),
        .lt_o(c_lt[g]), .eq_o(c_eq[g])
      );
    end
  end

  assign found = |c_eq;

  always_comb begin
    hit_off = '0;
    hit_len = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_off = hit_off | (c_off[i] & {OFF_W{c_eq[i]}});
      hit_len = hit_len | (c_len[i] & {sit_pkg::LEN_W{c_eq[i]}});
    end
  end

endmodule

### sv/sit_pool.sv
// ----------------------------------------------------------------------------
// sit_pool
// Byte pool of stored names: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sit_pool #(
  parameter int POOL_BYTES = sit_pkg::POOL_BYTES_DEF,
  parameter int AW         = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [POOL_BYTES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
